/* rtl/sdct_pkg.sv */
// Package for the space-delimited command tokenizer.
// Result codes, field widths, byte constants and the result struct.
// No dependencies.
package sdct_pkg;

  localparam int MAX_ARGS_DEF = 16;
  localparam int MAX_LINE_DEF = 4096;

  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 5;
  localparam int START_W  = 12;
  localparam int LENGTH_W = 13;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [START_W-1:0]  start_t;
  typedef logic [LENGTH_W-1:0] length_t;

  localparam status_t ST_TOKEN    = 3'd0;
  localparam status_t ST_END      = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_TOO_MANY = 3'd3;
  localparam status_t ST_TOO_LONG = 3'd4;

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;

  typedef struct packed {
    status_t status;
    index_t  token_index;
    start_t  token_start;
    length_t token_length;
    logic    is_last;
  } result_t;

endpackage

/* rtl/sdct_if.sv */
// Channel interfaces for the tokenizer: byte input and result output.
// Field widths are written out to match sdct_pkg; no dependencies.
interface sdct_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_line;

  modport source (output valid, output data_byte, output end_of_line, input ready);
  modport sink (input valid, input data_byte, input end_of_line, output ready);
endinterface

interface sdct_result_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              status;
  logic [4:0]              token_index;
  logic [11:0]             token_start;
  logic [12:0]             token_length;
  logic                    is_last;

  modport source (output valid, output status, output token_index, output token_start,
                  output token_length, output is_last, input ready);
  modport sink (input valid, input status, input token_index, input token_start,
                input token_length, input is_last, output ready);
endinterface

/* rtl/sdct_scan.sv */
// Line state registers and the per-byte update logic of the tokenizer.
// Depends on sdct_pkg; produces at most one result per accepted byte.
module sdct_scan #(
  parameter int MAX_ARGS = sdct_pkg::MAX_ARGS_DEF,
  parameter int MAX_LINE = sdct_pkg::MAX_LINE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       data_byte,
  input  logic             end_of_line,
  output logic             res_valid,
  output sdct_pkg::result_t res
);
  import sdct_pkg::*;

  localparam int POS_W = $clog2(MAX_LINE + 1);
  localparam int CNT_W = $clog2(MAX_ARGS + 2);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             inside_token, inside_token_next;
  logic [POS_W-1:0] current_token_start, current_token_start_next;
  logic [CNT_W-1:0] tokens_seen, tokens_seen_next;
  logic [POS_W-1:0] trailing_crlf_run, trailing_crlf_run_next;
  logic             line_aborted, line_aborted_next;

  logic             is_space, is_crlf, too_many, emitted, clear;
  logic [POS_W-1:0] pos_inc, close_len, end_len, crlf_base;

  always_comb begin
    is_space  = (data_byte == SPACE_BYTE);
    is_crlf   = (data_byte == CR_BYTE) || (data_byte == LF_BYTE);
    too_many  = (tokens_seen > CNT_W'(MAX_ARGS));
    pos_inc   = byte_position + POS_W'(1);
    close_len = byte_position - current_token_start;

    byte_position_next       = byte_position;
    inside_token_next        = inside_token;
    current_token_start_next = current_token_start;
    tokens_seen_next         = tokens_seen;
    trailing_crlf_run_next   = trailing_crlf_run;
    line_aborted_next        = line_aborted;
    crlf_base                = trailing_crlf_run;
    end_len                  = '0;
    emitted                  = 1'b0;
    clear                    = 1'b0;
    res_valid                = 1'b0;
    res                      = '0;

    if (line_aborted) begin
      clear = end_of_line;
    end else if (byte_position >= POS_W'(MAX_LINE)) begin
      res_valid         = 1'b1;
      res.status        = ST_TOO_LONG;
      res.is_last       = 1'b1;
      clear             = end_of_line;
      line_aborted_next = 1'b1;
    end else begin
      if (is_space) begin
        if (inside_token) begin
          inside_token_next      = 1'b0;
          trailing_crlf_run_next = '0;
          emitted                = 1'b1;
          res_valid              = 1'b1;
          if (too_many) begin
            res.status        = ST_TOO_MANY;
            res.is_last       = 1'b1;
            line_aborted_next = 1'b1;
          end else begin
            res.status       = ST_TOKEN;
            res.token_index  = index_t'(tokens_seen);
            res.token_start  = start_t'(current_token_start);
            res.token_length = length_t'(close_len);
            res.is_last      = end_of_line;
            tokens_seen_next = tokens_seen + CNT_W'(1);
          end
        end
      end else begin
        if (!inside_token) begin
          inside_token_next        = 1'b1;
          current_token_start_next = byte_position;
          crlf_base                = '0;
        end
        trailing_crlf_run_next = is_crlf ? crlf_base + POS_W'(1) : '0;
      end
      byte_position_next = pos_inc;

      if (end_of_line) begin
        clear = 1'b1;
        // Line end with no result yet: flush the trimmed open token (or report too many), else report end or empty.
        if (!emitted) begin
          if (inside_token_next)
            end_len = pos_inc - current_token_start_next - trailing_crlf_run_next;
          res_valid   = 1'b1;
          res.is_last = 1'b1;
          if (end_len != '0) begin
            if (too_many) begin
              res.status = ST_TOO_MANY;
            end else begin
              res.status       = ST_TOKEN;
              res.token_index  = index_t'(tokens_seen);
              res.token_start  = start_t'(current_token_start_next);
              res.token_length = length_t'(end_len);
            end
          end else if (tokens_seen == '0) begin
            res.status = ST_EMPTY;
          end else begin
            res.status = ST_END;
          end
        end
      end
    end

    if (clear) begin
      byte_position_next       = '0;
      inside_token_next        = 1'b0;
      current_token_start_next = '0;
      tokens_seen_next         = '0;
      trailing_crlf_run_next   = '0;
      line_aborted_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      inside_token        <= 1'b0;
      current_token_start <= '0;
      tokens_seen         <= '0;
      trailing_crlf_run   <= '0;
      line_aborted        <= 1'b0;
    end else if (take) begin
      byte_position       <= byte_position_next;
      inside_token        <= inside_token_next;
      current_token_start <= current_token_start_next;
      tokens_seen         <= tokens_seen_next;
      trailing_crlf_run   <= trailing_crlf_run_next;
      line_aborted        <= line_aborted_next;
    end
  end

endmodule

/* rtl/sdct_out_reg.sv */
// Result output register with valid/ready handshake.
// Depends on sdct_pkg for the result struct.
module sdct_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sdct_pkg::result_t res,
  output logic              space,
  output logic              valid,
  input  logic              ready,
  output sdct_pkg::result_t held
);
  import sdct_pkg::*;

  // Register can take new data when empty or being drained this cycle.
  assign space = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      held <= res;
    end
  end

endmodule

/* rtl/space_delimited_command_tokenizer_core.sv */
// Top level of the space-delimited command tokenizer.
// Depends on sdct_pkg, sdct_if, sdct_scan and sdct_out_reg.
//
//   channel   dir   carries
//   cmd_in    in    data_byte, end_of_line (one byte of a command line)
//   res_out   out   status, token_index, token_start, token_length, is_last
//
// One byte per cycle when cmd_in.ready is high; a result appears in the output register
// the cycle after its byte is accepted. Line state updates once per accepted byte.
// cmd_in.ready is low only while a result waits in the output register and
// res_out.ready is low. Synchronous reset clears line state and output valid.
module space_delimited_command_tokenizer_core #(
  parameter int MAX_ARGS = sdct_pkg::MAX_ARGS_DEF,
  parameter int MAX_LINE = sdct_pkg::MAX_LINE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  sdct_byte_if.sink     cmd_in,
  sdct_result_if.source res_out
);
  import sdct_pkg::*;

  logic    take, space, res_valid;
  result_t res, held;

  assign cmd_in.ready = space;
  assign take         = cmd_in.valid && space;

  sdct_scan #(
    .MAX_ARGS(MAX_ARGS),
    .MAX_LINE(MAX_LINE)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (cmd_in.data_byte),
    .end_of_line(cmd_in.end_of_line),
    .res_valid  (res_valid),
    .res        (res)
  );

  sdct_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (take && res_valid),
    .res  (res),
    .space(space),
    .valid(res_out.valid),
    .ready(res_out.ready),
    .held (held)
  );

  assign res_out.status       = held.status;
  assign res_out.token_index  = held.token_index;
  assign res_out.token_start  = held.token_start;
  assign res_out.token_length = held.token_length;
  assign res_out.is_last      = held.is_last;

endmodule

/* rtl/sdct_checker.sv */
// Port-level checks for the tokenizer core, attached by bind.
// Depends on sdct_pkg for result codes.
module sdct_checker #(
  parameter int MAX_ARGS = sdct_pkg::MAX_ARGS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [4:0]  token_index,
  input logic [11:0] token_start,
  input logic [12:0] token_length,
  input logic        is_last
);
  import sdct_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(token_index)
      && $stable(token_start) && $stable(token_length) && $stable(is_last))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_TOKEN |-> is_last && token_index == '0
      && token_start == '0 && token_length == '0)
    else $error("non-token result malformed");

  a_token_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_TOKEN |-> token_length != '0
      && 32'(token_index) <= MAX_ARGS)
    else $error("token result out of range");

endmodule

bind space_delimited_command_tokenizer_core sdct_checker #(.MAX_ARGS(MAX_ARGS)) u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (cmd_in.ready),
  .out_valid   (res_out.valid),
  .out_ready   (res_out.ready),
  .status      (res_out.status),
  .token_index (res_out.token_index),
  .token_start (res_out.token_start),
  .token_length(res_out.token_length),
  .is_last     (res_out.is_last)
);
